// File: rtl/afm_pkg.sv
package afm_pkg;

   // fixed field widths
   localparam int CNT_W = 16;
   localparam int SYM_W = 7;
   localparam int LEN_W = 6;

   // count increment per coded symbol
   localparam logic [CNT_W-1:0] COUNT_STEP = 16'd10;

   // rescale threshold after reset
   localparam logic [CNT_W-1:0] MAX_TOTAL_RESET = 16'd16383;

   // sequencer states
   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_RD1,
      ST_RD2,
      ST_RD3,
      ST_EMIT,
      ST_RESCALE,
      ST_RS_LAST,
      ST_SEARCH,
      ST_SW_RD,
      ST_SW_WR1,
      ST_SW_WR2,
      ST_CUM,
      ST_CUM_LAST
   } afm_state_type;

endpackage

// File: rtl/adaptive_frequency_model_top.sv
// Adaptive frequency model for an arithmetic coder, sorted by count.
// Input channel (req_valid / req_stall / req_symbol_index): one item names
// a model index 1..NUM_SYMBOLS. Result channel (rsp_valid / rsp_stall):
// one item per input with the cumulative range, the total and the mapped
// length, all as they stood before the update. Out-of-range indices give
// an all-zero result and leave the model untouched.
// Result: the lookup runs through ST_RD1, ST_RD2 and ST_RD3, then ST_EMIT
// loads the result register (an out-of-range index goes straight to
// ST_EMIT); ST_EMIT waits while the result register is busy.
// Throughput: no new item is taken until the update of the previous one
// has finished; moving the symbol adds a second swap write and a rescale
// adds a pass over the whole model. The rescale, the equal-count search
// and the cumulative increment each walk the entries one per cycle.
// Reset: synchronous. An initialising pass over every index loads the
// start state into the memory; no item is taken until it is done, while
// csr writes are taken at any time.
// Stall: the result register holds while rsp_stall is high. A new item is
// taken as soon as the previous update has finished, even if its result
// is still waiting; the next result then waits for the register to free.
// csr_write_enable / csr_write_data set the rescale threshold.
module adaptive_frequency_model_top
   import afm_pkg::*;
#(
   parameter int NUM_SYMBOLS = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_write_enable,
   input  logic [CNT_W-1:0] csr_write_data,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [SYM_W-1:0] req_symbol_index,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [CNT_W-1:0] rsp_range_low,
   output logic [CNT_W-1:0] rsp_range_high,
   output logic [CNT_W-1:0] rsp_total_count,
   output logic [LEN_W-1:0] rsp_mapped_length
);

   localparam int AW = $clog2(NUM_SYMBOLS + 1);
   localparam int VW = $clog2(NUM_SYMBOLS);
   localparam int EW = 2 * CNT_W + VW;

   // model memory: {count, cumulative count, value} per index
   logic [EW-1:0] model_mem [0:NUM_SYMBOLS];
   logic [EW-1:0] rd_data_ff;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [EW-1:0] wr_data;

   logic [CNT_W-1:0] q_cnt;
   logic [CNT_W-1:0] q_cum;
   logic [VW-1:0]    q_val;

   afm_state_type state_ff, state_in;
   logic [AW-1:0]    k_ff, k_in;
   logic             pend_ff, pend_in;
   logic [AW-1:0]    pend_addr_ff, pend_addr_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0] max_ff, max_in;

   logic [AW-1:0]    sym_ff, sym_in;
   logic             bad_ff, bad_in;
   logic [CNT_W-1:0] cnt_sym_ff, cnt_sym_in;
   logic [CNT_W-1:0] cum_sym_ff, cum_sym_in;
   logic [VW-1:0]    val_sym_ff, val_sym_in;
   logic [CNT_W-1:0] cum_high_ff, cum_high_in;
   logic [CNT_W-1:0] total_ff, total_in;
   logic [CNT_W-1:0] acc_ff, acc_in;
   logic [AW-1:0]    pos_ff, pos_in;
   logic [VW-1:0]    val_pos_ff, val_pos_in;
   logic [CNT_W-1:0] rsp_low_ff, rsp_low_in;
   logic [CNT_W-1:0] rsp_high_ff, rsp_high_in;
   logic [CNT_W-1:0] rsp_total_ff, rsp_total_in;
   logic [LEN_W-1:0] rsp_len_ff, rsp_len_in;

   logic              req_accept;
   logic              rsp_free;
   logic [AW+SYM_W-1:0] req_wide;
   logic [CNT_W:0]    half_sum;
   logic [CNT_W-1:0]  half_cnt;
   logic [AW-1:0]     k_dec;
   logic [VW+LEN_W-1:0] len_wide;

   assign q_cnt = rd_data_ff[EW-1 -: CNT_W];
   assign q_cum = rd_data_ff[VW+CNT_W-1 : VW];
   assign q_val = rd_data_ff[VW-1:0];

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign req_wide   = {{AW{1'b0}}, req_symbol_index};
   assign half_sum   = {1'b0, q_cnt} + {{CNT_W{1'b0}}, 1'b1};
   assign half_cnt   = half_sum[CNT_W:1];
   assign k_dec      = k_ff - {{(AW-1){1'b0}}, 1'b1};
   assign len_wide   = {{LEN_W{1'b0}}, val_sym_ff};

   // sequencer: next state, memory access and register updates
   always_comb begin
      state_in     = state_ff;
      k_in         = k_ff;
      pend_in      = 1'b0;
      pend_addr_in = k_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      max_in       = csr_write_enable ? csr_write_data : max_ff;
      sym_in       = sym_ff;
      bad_in       = bad_ff;
      cnt_sym_in   = cnt_sym_ff;
      cum_sym_in   = cum_sym_ff;
      val_sym_in   = val_sym_ff;
      cum_high_in  = cum_high_ff;
      total_in     = total_ff;
      acc_in       = acc_ff;
      pos_in       = pos_ff;
      val_pos_in   = val_pos_ff;
      rsp_low_in   = rsp_low_ff;
      rsp_high_in  = rsp_high_ff;
      rsp_total_in = rsp_total_ff;
      rsp_len_in   = rsp_len_ff;
      rd_en        = 1'b0;
      rd_addr      = k_ff;
      wr_en        = 1'b0;
      wr_addr      = pend_addr_ff;
      wr_data      = rd_data_ff;

      case (state_ff)
         // load the start state, one entry per cycle
         ST_INIT: begin
            wr_en   = 1'b1;
            wr_addr = k_ff;
            if (k_ff == '0) begin
               // index zero: no count, cumulative count is the start total
               wr_data = {{CNT_W{1'b0}}, CNT_W'(NUM_SYMBOLS), {VW{1'b0}}};
            end else begin
               wr_data = {{{(CNT_W-1){1'b0}}, 1'b1},
                          CNT_W'(NUM_SYMBOLS) - CNT_W'(k_ff), k_dec[VW-1:0]};
            end
            if (k_ff == AW'(NUM_SYMBOLS)) begin
               state_in = ST_IDLE;
            end else begin
               k_in = k_ff + {{(AW-1){1'b0}}, 1'b1};
            end
         end

         ST_IDLE: begin
            if (req_accept) begin
               sym_in = req_wide[AW-1:0];
               if (req_symbol_index == '0 || int'(req_symbol_index) > NUM_SYMBOLS) begin
                  bad_in   = 1'b1;
                  state_in = ST_EMIT;
               end else begin
                  bad_in   = 1'b0;
                  rd_en    = 1'b1;
                  rd_addr  = req_wide[AW-1:0];
                  state_in = ST_RD1;
               end
            end
         end

         // entry at the symbol arrives; fetch the one above it
         ST_RD1: begin
            cnt_sym_in = q_cnt;
            cum_sym_in = q_cum;
            val_sym_in = q_val;
            rd_en      = 1'b1;
            rd_addr    = sym_ff - {{(AW-1){1'b0}}, 1'b1};
            state_in   = ST_RD2;
         end

         ST_RD2: begin
            cum_high_in = q_cum;
            rd_en       = 1'b1;
            rd_addr     = '0;
            state_in    = ST_RD3;
         end

         ST_RD3: begin
            total_in = q_cum;
            state_in = ST_EMIT;
         end

         // load the result register, then pick the update path
         ST_EMIT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               if (bad_ff) begin
                  rsp_low_in   = '0;
                  rsp_high_in  = '0;
                  rsp_total_in = '0;
                  rsp_len_in   = '0;
                  state_in     = ST_IDLE;
               end else begin
                  rsp_low_in   = cum_sym_ff;
                  rsp_high_in  = cum_high_ff;
                  rsp_total_in = total_ff;
                  rsp_len_in   = len_wide[LEN_W-1:0];
                  if (({1'b0, total_ff} + {1'b0, COUNT_STEP}) > {1'b0, max_ff}) begin
                     k_in     = AW'(NUM_SYMBOLS);
                     acc_in   = '0;
                     state_in = ST_RESCALE;
                  end else begin
                     k_in     = sym_ff - {{(AW-1){1'b0}}, 1'b1};
                     state_in = ST_SEARCH;
                  end
               end
            end
         end

         // halve counts from the top, rebuilding cumulative counts
         ST_RESCALE, ST_RS_LAST: begin
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_data = {half_cnt, acc_ff, q_val};
               acc_in  = acc_ff + half_cnt;
               if (pend_addr_ff == sym_ff) begin
                  cnt_sym_in = half_cnt;
                  cum_sym_in = acc_ff;
               end
            end
            if (state_ff == ST_RESCALE) begin
               rd_en   = 1'b1;
               pend_in = 1'b1;
               if (k_ff == '0) begin
                  state_in = ST_RS_LAST;
               end else begin
                  k_in = k_dec;
               end
            end else begin
               k_in     = sym_ff - {{(AW-1){1'b0}}, 1'b1};
               state_in = ST_SEARCH;
            end
         end

         // walk down until the count differs; index zero always differs
         ST_SEARCH: begin
            if (pend_ff && q_cnt != cnt_sym_ff) begin
               pos_in   = pend_addr_ff + {{(AW-1){1'b0}}, 1'b1};
               state_in = ST_SW_RD;
            end else begin
               rd_en   = 1'b1;
               pend_in = 1'b1;
               if (k_ff != '0) begin
                  k_in = k_dec;
               end
            end
         end

         ST_SW_RD: begin
            rd_en    = 1'b1;
            rd_addr  = pos_ff;
            state_in = ST_SW_WR1;
         end

         // new leader entry takes the symbol's value and the increment
         ST_SW_WR1: begin
            wr_en      = 1'b1;
            wr_addr    = pos_ff;
            wr_data    = {cnt_sym_ff + COUNT_STEP, q_cum, val_sym_ff};
            val_pos_in = q_val;
            k_in       = pos_ff - {{(AW-1){1'b0}}, 1'b1};
            if (pos_ff != sym_ff) begin
               state_in = ST_SW_WR2;
            end else begin
               state_in = ST_CUM;
            end
         end

         ST_SW_WR2: begin
            wr_en    = 1'b1;
            wr_addr  = sym_ff;
            wr_data  = {cnt_sym_ff, cum_sym_ff, val_pos_ff};
            state_in = ST_CUM;
         end

         // add the step to every cumulative count above the new position
         ST_CUM, ST_CUM_LAST: begin
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_data = {q_cnt, q_cum + COUNT_STEP, q_val};
            end
            if (state_ff == ST_CUM) begin
               rd_en   = 1'b1;
               pend_in = 1'b1;
               if (k_ff == '0) begin
                  state_in = ST_CUM_LAST;
               end else begin
                  k_in = k_dec;
               end
            end else begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // model memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         model_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= model_mem[rd_addr];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         k_ff         <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         max_ff       <= MAX_TOTAL_RESET;
      end else begin
         state_ff     <= state_in;
         k_ff         <= k_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         max_ff       <= max_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pend_addr_ff <= pend_addr_in;
      sym_ff       <= sym_in;
      bad_ff       <= bad_in;
      cnt_sym_ff   <= cnt_sym_in;
      cum_sym_ff   <= cum_sym_in;
      val_sym_ff   <= val_sym_in;
      cum_high_ff  <= cum_high_in;
      total_ff     <= total_in;
      acc_ff       <= acc_in;
      pos_ff       <= pos_in;
      val_pos_ff   <= val_pos_in;
      rsp_low_ff   <= rsp_low_in;
      rsp_high_ff  <= rsp_high_in;
      rsp_total_ff <= rsp_total_in;
      rsp_len_ff   <= rsp_len_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_range_low     = rsp_low_ff;
   assign rsp_range_high    = rsp_high_ff;
   assign rsp_total_count   = rsp_total_ff;
   assign rsp_mapped_length = rsp_len_ff;

   // search must stop at index zero at the latest
   a_search_stops: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEARCH && pend_ff && pend_addr_ff == '0) |-> (q_cnt != cnt_sym_ff))
      else $error("equal-count search ran past index zero");

   // the symbol only moves toward the front, never to index zero
   a_pos_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SW_WR1) |-> (pos_ff != '0 && pos_ff <= sym_ff))
      else $error("swap position out of range");

   // the lookup reads never overlap a memory write
   a_lookup_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RD1 || state_ff == ST_RD2 || state_ff == ST_RD3) |-> !wr_en)
      else $error("memory write during lookup");

   // a new result is loaded only once the previous one was taken
   a_rsp_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> (rsp_valid_ff && $stable(rsp_low_ff)))
      else $error("pending result overwritten");

endmodule
